### rtl/core/fec_pkg.sv
// ----------------------------------------------------------------------------
// fec_pkg
// Shared types, constants and the extension table of the file extension
// classifier.
// ----------------------------------------------------------------------------
package fec_pkg;

   // Name handling
   localparam int NAME_LIMIT = 250;
   localparam int TAIL_LEN   = 5;
   localparam int LEN_W      = 8;
   localparam int LEN_MAX    = (1 << LEN_W) - 1;

   // Extension table geometry
   localparam int GROUPS    = 7;
   localparam int PER_GROUP = 4;
   localparam int MAX_EXT   = 4;
   localparam int ENTRIES   = GROUPS * PER_GROUP;
   localparam int ENTRY_W   = $clog2(ENTRIES);
   localparam int POS_W     = $clog2(TAIL_LEN);
   localparam int EXT_LEN_W = $clog2(MAX_EXT + 1);

   // Character codes
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;
   localparam logic [7:0] CHAR_END     = 8'h00;

   typedef logic [7:0]                 byte_type;
   typedef logic [TAIL_LEN-1:0][7:0]   tail_type;
   typedef logic [LEN_W-1:0]           len_type;

   typedef struct packed {
      logic                          recognized;
      logic [2:0]                    class_index;
      logic [1:0]                    sub_index;
   } result_type;

   typedef struct packed {
      logic [EXT_LEN_W-1:0]          len;
      logic [MAX_EXT-1:0][7:0]       ch;   // ch[0] is the first character
   } ext_entry_type;

   // Fold lower case (and anything above it) down by 0x20
   function automatic byte_type to_upper(input byte_type c);
      return (c >= CHAR_LOWER_A) ? byte_type'(c - CASE_OFFSET) : c;
   endfunction

   function automatic ext_entry_type mk(input int n, input byte_type c0, input byte_type c1,
                                        input byte_type c2, input byte_type c3);
      ext_entry_type e;
      e.len   = EXT_LEN_W'(n);
      e.ch[0] = c0;
      e.ch[1] = c1;
      e.ch[2] = c2;
      e.ch[3] = c3;
      return e;
   endfunction

   // Table in group-major order; empty slots sit at the end of their group
   function automatic ext_entry_type ext_entry(input logic [ENTRY_W-1:0] idx);
      ext_entry_type e;
      case (idx)
         5'd0:    e = mk(3, "B", "I", "N", 8'h00);
         5'd4:    e = mk(3, "L", "R", "C", 8'h00);
         5'd8:    e = mk(3, "N", "E", "S", 8'h00);
         5'd9:    e = mk(3, "S", "M", "S", 8'h00);
         5'd12:   e = mk(3, "T", "X", "T", 8'h00);
         5'd13:   e = mk(1, "C", 8'h00, 8'h00, 8'h00);
         5'd14:   e = mk(1, "H", 8'h00, 8'h00, 8'h00);
         5'd16:   e = mk(3, "W", "A", "V", 8'h00);
         5'd17:   e = mk(3, "M", "P", "3", 8'h00);
         5'd18:   e = mk(3, "A", "P", "E", 8'h00);
         5'd19:   e = mk(4, "F", "L", "A", "C");
         5'd20:   e = mk(3, "B", "M", "P", 8'h00);
         5'd21:   e = mk(3, "J", "P", "G", 8'h00);
         5'd22:   e = mk(4, "J", "P", "E", "G");
         5'd23:   e = mk(3, "G", "I", "F", 8'h00);
         5'd24:   e = mk(3, "A", "V", "I", 8'h00);
         default: e = mk(0, 8'h00, 8'h00, 8'h00, 8'h00);
      endcase
      return e;
   endfunction

endpackage

### rtl/core/fec_if.sv
// ----------------------------------------------------------------------------
// fec_req_if / fec_rsp_if
// Valid/ready channels of the file extension classifier.
// ----------------------------------------------------------------------------
interface fec_req_if;
   logic                 valid;
   logic                 ready;
   fec_pkg::byte_type    name_byte;

   modport source (output valid, output name_byte, input ready);
   modport sink   (input valid, input name_byte, output ready);
endinterface

interface fec_rsp_if;
   logic         valid;
   logic         ready;
   logic         recognized;
   logic [2:0]   class_index;
   logic [1:0]   sub_index;

   modport source (output valid, output recognized, output class_index,
                   output sub_index, input ready);
   modport sink   (input valid, input recognized, input class_index,
                   input sub_index, output ready);
endinterface

### rtl/core/fec_window.sv
// ----------------------------------------------------------------------------
// fec_window
// Keeps the newest name bytes and a saturating length count; clears both
// when the terminator beat is taken.
// ----------------------------------------------------------------------------
module fec_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  fec_pkg::byte_type  name_byte,
   output fec_pkg::tail_type  tail,
   output fec_pkg::len_type   name_len
);
   import fec_pkg::*;

   tail_type tail_ff, tail_in;
   len_type  len_ff,  len_in;

   // Shift in a byte, or clear on the terminator
   always_comb begin
      tail_in = tail_ff;
      len_in  = len_ff;
      if (take) begin
         if (name_byte == CHAR_END) begin
            tail_in = '0;
            len_in  = '0;
         end else begin
            tail_in = {tail_ff[TAIL_LEN-2:0], name_byte};
            if (len_ff != len_type'(LEN_MAX)) begin
               len_in = len_ff + len_type'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= '0;
         len_ff  <= '0;
      end else begin
         tail_ff <= tail_in;
         len_ff  <= len_in;
      end
   end

   assign tail     = tail_ff;
   assign name_len = len_ff;

endmodule

### rtl/core/fec_match.sv
// ----------------------------------------------------------------------------
// fec_match
// Finds the rightmost dot in the tail window and compares the extension
// against every table entry in parallel.
// ----------------------------------------------------------------------------
module fec_match (
   input  fec_pkg::tail_type    tail,
   input  fec_pkg::len_type     name_len,
   output fec_pkg::result_type  result
);
   import fec_pkg::*;

   logic              dot_found;
   logic [POS_W-1:0]  dot_pos;
   logic              too_long;
   logic [ENTRIES-1:0] hit;

   assign too_long = (name_len >= len_type'(NAME_LIMIT - 1));

   // Newest dot wins; only bytes of the current name count
   always_comb begin
      dot_found = 1'b0;
      dot_pos   = '0;
      for (int k = TAIL_LEN - 1; k >= 0; k--) begin
         if (tail[k] == CHAR_DOT && len_type'(k) < name_len) begin
            dot_found = 1'b1;
            dot_pos   = POS_W'(k);
         end
      end
   end

   // Per-entry compare: dot sits just before the extension, characters match
   always_comb begin
      ext_entry_type e;
      logic          ok;
      int            idx;
      for (int n = 0; n < ENTRIES; n++) begin
         e  = ext_entry(ENTRY_W'(n));
         ok = (e.len != '0) && (int'(e.len) < TAIL_LEN) && dot_found
              && (int'(dot_pos) == int'(e.len));
         for (int m = 0; m < MAX_EXT; m++) begin
            idx = int'(e.len) - 1 - m;
            if (m < int'(e.len) && idx >= 0 && idx < TAIL_LEN) begin
               if (to_upper(tail[idx[POS_W-1:0]]) != e.ch[m]) begin
                  ok = 1'b0;
               end
            end
         end
         hit[n] = ok;
      end
   end

   // First hit in table order gives group and slot
   always_comb begin
      result = '0;
      if (!too_long) begin
         for (int n = ENTRIES - 1; n >= 0; n--) begin
            if (hit[n]) begin
               result.recognized  = 1'b1;
               result.class_index = 3'(n / PER_GROUP);
               result.sub_index   = 2'(n % PER_GROUP);
            end
         end
      end
   end

endmodule

### rtl/core/file_extension_classifier.sv
// ----------------------------------------------------------------------------
// file_extension_classifier
// Classifies a file name, streamed one byte per beat, by its extension.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one name byte per beat; a zero byte ends the name.
//   rsp_chan carries one result beat per terminator: recognized, the group
//   (class_index) and the slot inside the group (sub_index). Other bytes
//   produce no result beat.
//   Result: registered; it appears in the cycle after the terminator beat is taken.
//   Throughput: one byte per cycle, except a terminator that waits on a stall.
//   The window shift, the dot search and the table compares all fit between
//   the window registers and the result register.
//   Stall: the result register holds its beat while rsp_chan.ready is low;
//   name bytes are still taken, and only a terminator waits until the
//   pending result is gone.
//   Reset: synchronous, active high; clears the window, the length count and
//   the result valid. The block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module file_extension_classifier (
   input  logic        clock,
   input  logic        reset,
   fec_req_if.sink     req_chan,
   fec_rsp_if.source   rsp_chan
);
   import fec_pkg::*;

   tail_type   tail;
   len_type    name_len;
   result_type match_res;
   result_type res_ff, res_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;
   logic       take;
   logic       take_end;

   // Result register free, or emptied this cycle
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Name bytes always flow; a terminator needs a free result slot
   assign req_chan.ready = slot_free || (req_chan.name_byte != CHAR_END);
   assign take           = req_chan.valid && req_chan.ready;
   assign take_end       = take && (req_chan.name_byte == CHAR_END);

   fec_window u_window (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .name_byte (req_chan.name_byte),
      .tail      (tail),
      .name_len  (name_len)
   );

   fec_match u_match (
      .tail     (tail),
      .name_len (name_len),
      .result   (match_res)
   );

   // Output register
   always_comb begin
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (take_end) begin
         res_in       = match_res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.recognized  = res_ff.recognized;
   assign rsp_chan.class_index = res_ff.class_index;
   assign rsp_chan.sub_index   = res_ff.sub_index;

   // Terminator always yields a result beat next cycle
   a_end_gives_beat: assert property (@(posedge clock) disable iff (reset)
      take_end |=> rsp_chan.valid)
      else $error("terminator beat did not produce a result");

   // Ordinary bytes never create a result beat
   a_byte_no_beat: assert property (@(posedge clock) disable iff (reset)
      (take && !take_end) |=> (rsp_chan.valid == $past(rsp_valid_ff && !rsp_chan.ready)))
      else $error("result beat appeared without a terminator");

   // Name state clears after the terminator
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      take_end |=> (name_len == '0 && tail == '0))
      else $error("window not cleared after terminator");

   // Unrecognized results carry zero group and slot
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.recognized)
         |-> (rsp_chan.class_index == '0 && rsp_chan.sub_index == '0))
      else $error("unrecognized result with nonzero indexes");

endmodule
